[design/vnf_pkg.sv]
// Shared types, constants and arithmetic helpers for the 3D fractal value noise block.
// Used by vnf_octave and value_noise_fbm_3d; depends on nothing else.
`default_nettype none

package vnf_pkg;

	localparam int OCTAVE_COUNT = 4;

	localparam int POS_W   = 36;  // signed Q16.20 position
	localparam int COORD_W = 32;  // signed Q12.20 input coordinate
	localparam int FRAC_W  = 24;  // Q0.24 fractions
	localparam int WGT_W   = 25;  // smoothstep weight, Q1.24
	localparam int SCL_W   = 29;  // 17 * fraction, Q5.24
	localparam int SUM_W   = 31;  // sx + sy + sz
	localparam int PXY_W   = 34;  // (sx * sy) >> 24
	localparam int PXYZ_W  = 39;  // (pxy * sz) >> 24
	localparam int OUT_W   = 16;

	localparam logic [22:0]       HASH_K = 23'd5340354;
	localparam logic [FRAC_W-1:0] HASH_B = 24'd1677722;

	// Stages inside one octave and over the whole pipe (position, octaves, output)
	localparam int OCT_LAT = 9;
	localparam int LAT     = OCT_LAT + 2;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [WGT_W-1:0]  wgt_t;

	// Offset after k position updates: 100 * (2^k - 1) in Q16.20, modulo 2^36
	function automatic pos_t oct_offset(input int k);
		pos_t base;
		pos_t mul;
		base = pos_t'(100) << 20;
		mul  = (pos_t'(1) << k) - pos_t'(1);
		return base * mul;
	endfunction

	// Linear blend of two Q0.24 values by a Q1.24 weight, products truncated
	function automatic frac_t lerp24(input frac_t a, input frac_t b, input wgt_t u);
		wgt_t               w;
		logic [48:0]        pa;
		logic [48:0]        pb;
		logic [FRAC_W:0]    s;
		w  = (wgt_t'(1) << FRAC_W) - u;
		pa = {24'd0, w} * {25'd0, a};
		pb = {24'd0, u} * {25'd0, b};
		s  = pa[48:24] + pb[48:24];
		return s[FRAC_W-1:0];
	endfunction

endpackage

`default_nettype wire

[design/vnf_octave.sv]
// One octave of 3D value noise: lattice hashing, smoothstep and trilinear blend.
// Nine register stages, all advanced by one enable; depends on vnf_pkg.
`default_nettype none

module vnf_octave
	import vnf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  en,
	input  wire pos_t  pos [3],
	output frac_t      noise
);

	logic [FRAC_W-1:0] qr_s1  [3][2];
	frac_t             f_s1   [3];
	frac_t             ff_s1  [3];
	logic [SCL_W-1:0]  s_s2   [3][2];
	wgt_t              u_s2   [3];
	logic [PXY_W-1:0]  pxy_s3 [8];
	logic [SUM_W-1:0]  sum_s3 [8];
	logic [SCL_W-1:0]  sz_s3  [8];
	wgt_t              u_s3   [3];
	logic [PXYZ_W-1:0] p_s4   [8];
	logic [SUM_W-1:0]  sum_s4 [8];
	wgt_t              u_s4   [3];
	logic [47:0]       lo_s5  [8];
	frac_t             hi_s5  [8];
	wgt_t              u_s5   [3];
	frac_t             h_s6   [8];
	wgt_t              u_s6   [3];
	frac_t             row_s7 [4];
	wgt_t              u_s7   [3];
	frac_t             lay_s8 [2];
	wgt_t              u_s8   [3];
	frac_t             n_s9;

	// Stage 1: corner coordinate times the hash scale, fraction squared
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				for (int d = 0; d < 2; d++) begin
					logic [16:0] c17;
					logic [23:0] c24;
					logic [46:0] m;
					c17 = {pos[a][POS_W-1], pos[a][POS_W-1:20]} + 17'(d);
					c24 = {{7{c17[16]}}, c17};
					m   = c24 * {24'd0, HASH_K};
					qr_s1[a][d] <= m[FRAC_W-1:0];
				end
				f_s1[a]  <= {pos[a][19:0], 4'd0};
				ff_s1[a] <= 24'((({24'd0, pos[a][19:0], 4'd0}) *
					{24'd0, pos[a][19:0], 4'd0}) >> FRAC_W);
			end
		end
	end

	// Stage 2: add bias, keep fraction, times 17; smoothstep weight
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				logic [FRAC_W-1:0] q;
				logic [25:0]       t;
				logic [49:0]       m;
				for (int d = 0; d < 2; d++) begin
					q = qr_s1[a][d] + HASH_B;
					s_s2[a][d] <= ({5'd0, q} << 4) + {5'd0, q};
				end
				t = (26'd3 << FRAC_W) - {1'b0, f_s1[a], 1'b0};
				m = {26'd0, ff_s1[a]} * {24'd0, t};
				u_s2[a] <= m[48:24];
			end
		end
	end

	// Stage 3: sx * sy per corner, coordinate sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				logic [57:0] m;
				m = {29'd0, s_s2[0][i%2]} * {29'd0, s_s2[1][(i/2)%2]};
				pxy_s3[i] <= m[57:24];
				sum_s3[i] <= {2'd0, s_s2[0][i%2]} + {2'd0, s_s2[1][(i/2)%2]} +
					{2'd0, s_s2[2][i/4]};
				sz_s3[i]  <= s_s2[2][i/4];
			end
			u_s3 <= u_s2;
		end
	end

	// Stage 4: times sz
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				logic [62:0] m;
				m = {29'd0, pxy_s3[i]} * {34'd0, sz_s3[i]};
				p_s4[i] <= m[62:24];
			end
			sum_s4 <= sum_s3;
			u_s4   <= u_s3;
		end
	end

	// Stage 5: times the sum, split into low and high partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				logic [54:0] ml;
				logic [45:0] mh;
				ml = {31'd0, p_s4[i][23:0]} * {24'd0, sum_s4[i]};
				mh = {31'd0, p_s4[i][38:24]} * {15'd0, sum_s4[i]};
				lo_s5[i] <= ml[47:0];
				hi_s5[i] <= mh[23:0];
			end
			u_s5 <= u_s4;
		end
	end

	// Stage 6: hash fraction, bits 24..47 of the product
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++)
				h_s6[i] <= lo_s5[i][47:24] + hi_s5[i];
			u_s6 <= u_s5;
		end
	end

	// Stage 7: blend along x
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++)
				row_s7[j] <= lerp24(h_s6[2*j], h_s6[2*j+1], u_s6[0]);
			u_s7 <= u_s6;
		end
	end

	// Stage 8: blend along y
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++)
				lay_s8[k] <= lerp24(row_s7[2*k], row_s7[2*k+1], u_s7[1]);
			u_s8 <= u_s7;
		end
	end

	// Stage 9: blend along z
	always_ff @(posedge clk) begin
		if (en)
			n_s9 <= lerp24(lay_s8[0], lay_s8[1], u_s8[2]);
	end

	assign noise = n_s9;

endmodule

`default_nettype wire

[design/value_noise_fbm_3d.sv]
// Top level of the four-octave 3D fractal value noise pipeline.
// Depends on vnf_pkg and vnf_octave.
//
// Usage:
//   Input channel: coord_x, coord_y, coord_z (signed Q12.20) with in_valid and
//   in_stall; an item is taken on a clock edge with in_valid high and in_stall low.
//   Output channel: noise_value (unsigned Q0.16) with out_valid and out_stall.
//   Each input item gives exactly one result item, in order.
//   Pipeline from acceptance to out_valid:
//   one stage forms every octave position, nine stages run the octaves side by side,
//   one stage sums the weighted octaves into the output register.
//   One item per cycle unless stalled; every octave has its own hash multipliers.
//   Reset (arst_n low) clears all valid bits; the pipe comes up empty and ready.
//   While a result waits with out_stall high, the whole pipe holds and in_stall is
//   raised; nothing is lost or repeated. Bubbles flow out without blocking input.
`default_nettype none

module value_noise_fbm_3d
	import vnf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic signed [31:0]  coord_x,
	input  wire logic signed [31:0]  coord_y,
	input  wire logic signed [31:0]  coord_z,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [OUT_W-1:0]         noise_value
);

	logic              en;
	logic [LAT-1:0]    vld_s;
	pos_t              pos_s1  [OCTAVE_COUNT][3];
	frac_t             noise_k [OCTAVE_COUNT];
	frac_t             sum;
	logic [OUT_W-1:0]  nv_s11;

	// Hold the whole pipe while a finished item waits
	assign en       = !(vld_s[LAT-1] && out_stall);
	assign in_stall = vld_s[LAT-1] && out_stall;

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	// Stage 1: position of each octave, 2^k p + offset, wrapped to 36 bits
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < OCTAVE_COUNT; k++) begin
				pos_s1[k][0] <= (pos_t'(coord_x) << k) + oct_offset(k);
				pos_s1[k][1] <= (pos_t'(coord_y) << k) + oct_offset(k);
				pos_s1[k][2] <= (pos_t'(coord_z) << k) + oct_offset(k);
			end
		end
	end

	// Octave pipes, all with the same latency
	for (genvar g = 0; g < OCTAVE_COUNT; g++) begin : g_oct
		vnf_octave u_oct (
			.clk   (clk),
			.en    (en),
			.pos   (pos_s1[g]),
			.noise (noise_k[g])
		);
	end

	// Weight octave k by 2^-(k+1) and sum
	always_comb begin
		sum = '0;
		for (int k = 0; k < OCTAVE_COUNT; k++)
			sum = sum + (noise_k[k] >> (k + 1));
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en)
			nv_s11 <= sum[FRAC_W-1:FRAC_W-OUT_W];
	end

	assign out_valid   = vld_s[LAT-1];
	assign noise_value = nv_s11;

`ifndef SYNTH
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("valid bits moved while the pipe was held");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_valid) |=> vld_s[0])
		else $error("accepted item did not enter the pipe");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input held without a waiting result");
`endif

endmodule

`default_nettype wire

[verif/value_noise_fbm_3d_tb.sv]
// Self-checking testbench for value_noise_fbm_3d: random and directed points, random stalls.
// Depends on vnf_pkg and the value_noise_fbm_3d RTL; expected noise computed in-bench.
`default_nettype none

module value_noise_fbm_3d_tb
	import vnf_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic out_valid;
	logic out_stall;
	logic [OUT_W-1:0] noise_value;

	point_t pending_points[$];
	logic [OUT_W-1:0] expected_noise[$];
	int fail_count;
	int accepted_points;
	int checked_results;
	int idle_cycles;
	bit stimulus_done;
	bit hold_off_req;
	int send_gap;
	int recv_gap;

	value_noise_fbm_3d dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
	);

	// Clock: 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// 17 times the fraction of the scaled and biased corner coordinate, Q5.24
	function automatic logic [63:0] corner_scale(input logic signed [31:0] c);
		logic [63:0] t;
		t = 64'(signed'(c)) * 64'd5340354 + 64'd1677722;
		return (t & 64'hFFFFFF) * 64'd17;
	endfunction

	function automatic logic [63:0] corner_hash(input logic signed [31:0] cx,
			input logic signed [31:0] cy, input logic signed [31:0] cz);
		logic [63:0] sx, sy, sz, p;
		sx = corner_scale(cx);
		sy = corner_scale(cy);
		sz = corner_scale(cz);
		p = (sx * sy) >> 24;
		p = (p * sz) >> 24;
		p = p * (sx + sy + sz);
		return (p >> 24) & 64'hFFFFFF;
	endfunction

	function automatic logic [63:0] mix(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] u);
		return ((((64'd1 << 24) - u) * a) >> 24) + ((u * b) >> 24);
	endfunction

	function automatic logic [63:0] fade(input logic [63:0] f);
		logic [63:0] f2;
		f2 = (f * f) >> 24;
		return (f2 * ((64'd3 << 24) - 2 * f)) >> 24;
	endfunction

	// One octave of trilinear value noise at a 36-bit position triple
	function automatic logic [63:0] octave_noise(input logic [35:0] px, input logic [35:0] py,
			input logic [35:0] pz);
		logic signed [31:0] ix, iy, iz;
		logic [63:0] ux, uy, uz, r0, r1, l0, l1;
		ix = 32'(signed'(px[35:20]));
		iy = 32'(signed'(py[35:20]));
		iz = 32'(signed'(pz[35:20]));
		ux = fade({40'd0, px[19:0], 4'd0});
		uy = fade({40'd0, py[19:0], 4'd0});
		uz = fade({40'd0, pz[19:0], 4'd0});
		r0 = mix(corner_hash(ix, iy, iz), corner_hash(ix + 1, iy, iz), ux);
		r1 = mix(corner_hash(ix, iy + 1, iz), corner_hash(ix + 1, iy + 1, iz), ux);
		l0 = mix(r0, r1, uy);
		r0 = mix(corner_hash(ix, iy, iz + 1), corner_hash(ix + 1, iy, iz + 1), ux);
		r1 = mix(corner_hash(ix, iy + 1, iz + 1), corner_hash(ix + 1, iy + 1, iz + 1), ux);
		l1 = mix(r0, r1, uy);
		return mix(l0, l1, uz);
	endfunction

	function automatic logic [OUT_W-1:0] fbm_noise(input point_t pt);
		logic [35:0] px, py, pz;
		logic [63:0] sum;
		px = 36'(signed'(pt.x));
		py = 36'(signed'(pt.y));
		pz = 36'(signed'(pt.z));
		sum = 0;
		for (int k = 0; k < OCTAVE_COUNT; k++) begin
			sum += octave_noise(px, py, pz) >> (k + 1);
			px = px * 2 + (36'd100 << 20);
			py = py * 2 + (36'd100 << 20);
			pz = pz * 2 + (36'd100 << 20);
		end
		return sum[23:8];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(signed'($urandom_range(0, 8191)) - 4096) << 20 | ($urandom & 32'hFFFFF);
			2: return {$urandom_range(0, 1) ? 12'hFFF : 12'h000, 20'($urandom)};
			default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 2**21)
				: 32'h8000_0000 + $urandom_range(0, 2**21);
		endcase
	endfunction

	// Stimulus: directed corners, then random points
	initial begin
		logic [31:0] edges[8];
		point_t p;
		edges = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h000FFFFF, 32'h00100000, 32'hFFF00000, 32'h55555555};
		for (int i = 0; i < 8; i++) begin
			p.x = edges[i];
			p.y = edges[(i + 3) % 8];
			p.z = edges[(i + 5) % 8];
			pending_points.push_back(p);
		end
		pending_points.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
		pending_points.push_back('{32'h80000000, 32'h80000000, 32'h80000000});
		pending_points.push_back('{32'h7FF00000, 32'h7FF80000, 32'h7FFFFFFF});
		pending_points.push_back('{32'hAAAAAAAA, 32'h33333333, 32'hCCCCCCCC});
		for (int i = 0; i < 1150; i++) begin
			p.x = rand_coord();
			p.y = rand_coord();
			p.z = rand_coord();
			pending_points.push_back(p);
		end
	end

	// Reset and end of run
	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (stimulus_done && expected_noise.size() == 0);
		repeat (20) @(posedge clk);
		$display("Checked %0d noise results from %0d points, with long output hold-off.",
			checked_results, accepted_points);
		if (fail_count == 0 && expected_noise.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Driver: offer points with random gaps, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			coord_x <= '0;
			coord_y <= '0;
			coord_z <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_noise.push_back(fbm_noise('{coord_x, coord_y, coord_z}));
				accepted_points++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0 || pending_points.size() == 0) begin
					in_valid <= 1'b0;
					if (send_gap > 0) send_gap <= send_gap - 1;
					if (pending_points.size() == 0)
						stimulus_done <= 1'b1;
				end else begin
					point_t p;
					p = pending_points.pop_front();
					in_valid <= 1'b1;
					coord_x <= p.x;
					coord_y <= p.y;
					coord_z <= p.z;
					send_gap <= pick_gap();
				end
			end
		end
	end

	// Monitor: random output stall, one long hold-off mid-run, compare results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_noise.size() == 0) begin
					$error("unexpected result noise_value=%0h", noise_value);
					fail_count++;
				end else begin
					logic [OUT_W-1:0] want;
					want = expected_noise.pop_front();
					if (noise_value !== want) begin
						$error("noise_value: expected %0h actual %0h", want, noise_value);
						fail_count++;
					end
					checked_results++;
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else if (accepted_points >= 300 && !hold_off_req) begin
				hold_off_req <= 1'b1;
				recv_gap <= 60;
				out_stall <= 1'b1;
			end else begin
				recv_gap <= pick_gap();
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: abort if no item moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire

[sim.f]
design/vnf_pkg.sv
design/vnf_octave.sv
design/value_noise_fbm_3d.sv
verif/value_noise_fbm_3d_tb.sv
